// ----- src/miex_pkg.sv -----
// Package: opcode, function, memory kind and fault codes, and controller types.
`default_nettype none
package miex_pkg;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_COP0    = 6'h10;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LWL     = 6'h22;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_LWR     = 6'h26;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SWL     = 6'h2A;
	localparam logic [5:0] OP_SW      = 6'h2B;
	localparam logic [5:0] OP_SWR     = 6'h2E;
	localparam logic [5:0] OP_CACHE   = 6'h2F;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_BREAK   = 6'h0D;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;
	localparam logic [5:0] FN_TEQ     = 6'h34;
	localparam logic [5:0] FN_TNE     = 6'h36;

	localparam logic [4:0] RI_BLTZ    = 5'h00;
	localparam logic [4:0] RI_BGEZ    = 5'h01;
	localparam logic [4:0] RI_BLTZAL  = 5'h10;
	localparam logic [4:0] RI_BGEZAL  = 5'h11;

	localparam logic [4:0] LINK_REG   = 5'd31;
	localparam int unsigned MD_STEPS  = 32;

	typedef enum logic [3:0] {
		MK_NONE = 4'd0, MK_LB = 4'd1, MK_LBU = 4'd2, MK_LH = 4'd3, MK_LHU = 4'd4,
		MK_LW = 4'd5, MK_LWL = 4'd6, MK_LWR = 4'd7, MK_SB = 4'd8, MK_SH = 4'd9,
		MK_SW = 4'd10, MK_SWL = 4'd11, MK_SWR = 4'd12
	} mem_kind_t;

	typedef enum logic [2:0] {
		FLT_NONE = 3'd0, FLT_OVF = 3'd1, FLT_ADEL = 3'd2, FLT_SYS = 3'd3,
		FLT_BRK = 3'd4, FLT_TRAP = 3'd5, FLT_RSVD = 3'd6
	} fault_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_RUN, ST_FIX
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic md_step;
		logic md_finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic md_req;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- src/miex_dpath.sv -----
// Datapath: decode, ALU, branch and address logic, HI/LO and shift-add/restoring mul-div unit.
`default_nettype none
module miex_dpath import miex_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	output dp_status_t       status,
	input  wire logic [31:0] instr_word,
	input  wire logic [31:0] instr_addr,
	input  wire logic [31:0] src_a,
	input  wire logic [31:0] src_b,
	output logic [4:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             dest_write,
	output logic             redirect,
	output logic [31:0]      redirect_target,
	output logic [3:0]       mem_kind,
	output logic [31:0]      mem_addr,
	output logic [31:0]      mem_store_data,
	output logic [2:0]       fault
);

	logic [31:0] hi_q, lo_q, acc_hi_q, acc_lo_q, opd_q;
	logic        div_q, neg_lo_q, neg_hi_q;

	logic [5:0]  op, fn;
	logic [4:0]  rt, rd, sa;
	logic [31:0] imm, simm, btgt, ea, r_add, r_sub, r_addi, pc8;
	logic [4:0]  di;
	logic [31:0] dv, tgt, ma, msd;
	logic        dw, rdir;
	mem_kind_t   mk;
	fault_t      flt;
	logic        is_md, md_signed, md_div, a_neg, b_neg;
	logic [31:0] abs_a, abs_b;
	logic [32:0] msum, dtrial;
	logic [63:0] prod_neg;

	assign op   = instr_word[31:26];
	assign rt   = instr_word[20:16];
	assign rd   = instr_word[15:11];
	assign sa   = instr_word[10:6];
	assign fn   = instr_word[5:0];
	assign imm  = {16'h0000, instr_word[15:0]};
	assign simm = {{16{instr_word[15]}}, instr_word[15:0]};
	assign btgt = instr_addr + 32'd4 + {simm[29:0], 2'b00};
	assign ea   = src_a + simm;
	assign pc8  = instr_addr + 32'd8;
	assign r_add  = src_a + src_b;
	assign r_sub  = src_a - src_b;
	assign r_addi = src_a + simm;

	assign is_md     = (op == OP_SPECIAL) && (fn inside {FN_MULT, FN_MULTU, FN_DIV, FN_DIVU});
	assign md_signed = (fn == FN_MULT) || (fn == FN_DIV);
	assign md_div    = (fn == FN_DIV) || (fn == FN_DIVU);
	assign a_neg     = md_signed & src_a[31];
	assign b_neg     = md_signed & src_b[31];
	assign abs_a     = a_neg ? (32'd0 - src_a) : src_a;
	assign abs_b     = b_neg ? (32'd0 - src_b) : src_b;
	assign status.md_req = is_md;

	always_comb begin
		di = 5'd0; dv = 32'd0; dw = 1'b0; rdir = 1'b0; tgt = 32'd0;
		mk = MK_NONE; ma = 32'd0; msd = 32'd0; flt = FLT_NONE;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL:  begin di = rd; dv = src_b << sa; dw = 1'b1; end
					FN_SRL:  begin di = rd; dv = src_b >> sa; dw = 1'b1; end
					FN_SRA:  begin di = rd; dv = $unsigned($signed(src_b) >>> sa); dw = 1'b1; end
					FN_SLLV: begin di = rd; dv = src_b << src_a[4:0]; dw = 1'b1; end
					FN_SRLV: begin di = rd; dv = src_b >> src_a[4:0]; dw = 1'b1; end
					FN_SRAV: begin
						di = rd; dv = $unsigned($signed(src_b) >>> src_a[4:0]); dw = 1'b1;
					end
					FN_JR:   begin rdir = 1'b1; tgt = src_a; end
					FN_JALR: begin rdir = 1'b1; tgt = src_a; di = rd; dv = pc8; dw = 1'b1; end
					FN_SYSCALL: flt = FLT_SYS;
					FN_BREAK:   flt = FLT_BRK;
					FN_MFHI: begin di = rd; dv = hi_q; dw = 1'b1; end
					FN_MFLO: begin di = rd; dv = lo_q; dw = 1'b1; end
					FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: ;
					FN_ADD: begin
						if (~(src_a[31] ^ src_b[31]) & (src_a[31] ^ r_add[31])) flt = FLT_OVF;
						else begin di = rd; dv = r_add; dw = 1'b1; end
					end
					FN_ADDU: begin di = rd; dv = r_add; dw = 1'b1; end
					FN_SUB: begin
						if ((src_a[31] ^ src_b[31]) & (src_a[31] ^ r_sub[31])) flt = FLT_OVF;
						else begin di = rd; dv = r_sub; dw = 1'b1; end
					end
					FN_SUBU: begin di = rd; dv = r_sub; dw = 1'b1; end
					FN_AND:  begin di = rd; dv = src_a & src_b; dw = 1'b1; end
					FN_OR:   begin di = rd; dv = src_a | src_b; dw = 1'b1; end
					FN_XOR:  begin di = rd; dv = src_a ^ src_b; dw = 1'b1; end
					FN_NOR:  begin di = rd; dv = ~(src_a | src_b); dw = 1'b1; end
					FN_SLT: begin
						di = rd; dv = {31'd0, $signed(src_a) < $signed(src_b)}; dw = 1'b1;
					end
					FN_SLTU: begin di = rd; dv = {31'd0, src_a < src_b}; dw = 1'b1; end
					FN_TEQ: if (src_a == src_b) flt = FLT_TRAP;
					FN_TNE: if (src_a != src_b) flt = FLT_TRAP;
					default: flt = FLT_RSVD;
				endcase
			end
			OP_REGIMM: begin
				if (rt inside {RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL}) begin
					if (rt[0] ^ src_a[31]) begin rdir = 1'b1; tgt = btgt; end
					if (rt[4]) begin di = LINK_REG; dv = pc8; dw = 1'b1; end
				end else begin
					flt = FLT_RSVD;
				end
			end
			OP_J, OP_JAL: begin
				rdir = 1'b1;
				tgt = {btgt[31:28] & 4'h0 | (instr_addr[31:28] + {3'd0, &instr_addr[27:2]}),
					instr_word[25:0], 2'b00};
				if (op == OP_JAL) begin di = LINK_REG; dv = pc8; dw = 1'b1; end
			end
			OP_BEQ:  if (src_a == src_b) begin rdir = 1'b1; tgt = btgt; end
			OP_BNE:  if (src_a != src_b) begin rdir = 1'b1; tgt = btgt; end
			OP_BLEZ: if ($signed(src_a) <= 0) begin rdir = 1'b1; tgt = btgt; end
			OP_BGTZ: if ($signed(src_a) > 0) begin rdir = 1'b1; tgt = btgt; end
			OP_ADDI: begin
				if (~(src_a[31] ^ simm[31]) & (src_a[31] ^ r_addi[31])) flt = FLT_OVF;
				else begin di = rt; dv = r_addi; dw = 1'b1; end
			end
			OP_ADDIU: begin di = rt; dv = r_addi; dw = 1'b1; end
			OP_SLTI: begin di = rt; dv = {31'd0, $signed(src_a) < $signed(simm)}; dw = 1'b1; end
			OP_SLTIU: begin di = rt; dv = {31'd0, src_a < simm}; dw = 1'b1; end
			OP_ANDI: begin di = rt; dv = src_a & imm; dw = 1'b1; end
			OP_ORI:  begin di = rt; dv = src_a | imm; dw = 1'b1; end
			OP_XORI: begin di = rt; dv = src_a ^ imm; dw = 1'b1; end
			OP_LUI:  begin di = rt; dv = {instr_word[15:0], 16'h0000}; dw = 1'b1; end
			OP_COP0, OP_CACHE: ;
			OP_LB:  begin mk = MK_LB;  ma = ea; di = rt; end
			OP_LBU: begin mk = MK_LBU; ma = ea; di = rt; end
			OP_LH, OP_LHU: begin
				ma = ea;
				if (ea[0]) flt = FLT_ADEL;
				else begin mk = (op == OP_LH) ? MK_LH : MK_LHU; di = rt; end
			end
			OP_LW: begin
				ma = ea;
				if (ea[1:0] != 2'b00) flt = FLT_ADEL;
				else begin mk = MK_LW; di = rt; end
			end
			OP_LWL: begin mk = MK_LWL; ma = ea; di = rt; end
			OP_LWR: begin mk = MK_LWR; ma = ea; di = rt; end
			OP_SB:  begin mk = MK_SB;  ma = ea; msd = src_b; end
			OP_SH:  begin mk = MK_SH;  ma = ea; msd = src_b; end
			OP_SW:  begin mk = MK_SW;  ma = ea; msd = src_b; end
			OP_SWL: begin mk = MK_SWL; ma = ea; msd = src_b; end
			OP_SWR: begin mk = MK_SWR; ma = ea; msd = src_b; end
			default: flt = FLT_RSVD;
		endcase
		if (dw && di == 5'd0) begin
			dw = 1'b0;
			dv = 32'd0;
		end
	end

	// one bit per step: shift-add multiply, restoring divide
	assign msum     = {1'b0, acc_hi_q} + (acc_lo_q[0] ? {1'b0, opd_q} : 33'd0);
	assign dtrial   = {acc_hi_q, acc_lo_q[31]} - {1'b0, opd_q};
	assign prod_neg = 64'd0 - {acc_hi_q, acc_lo_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dest_index      <= di;
			dest_value      <= dv;
			dest_write      <= dw;
			redirect        <= rdir;
			redirect_target <= tgt;
			mem_kind        <= mk;
			mem_addr        <= ma;
			mem_store_data  <= msd;
			fault           <= flt;
		end
		if (cmd.accept && is_md) begin
			acc_hi_q <= 32'd0;
			acc_lo_q <= md_div ? abs_a : abs_b;
			opd_q    <= md_div ? abs_b : abs_a;
			div_q    <= md_div;
			neg_lo_q <= a_neg ^ b_neg;
			neg_hi_q <= md_div ? a_neg : (a_neg ^ b_neg);
		end else if (cmd.md_step) begin
			if (div_q) begin
				if (!dtrial[32]) begin
					acc_hi_q <= dtrial[31:0];
					acc_lo_q <= {acc_lo_q[30:0], 1'b1};
				end else begin
					acc_hi_q <= {acc_hi_q[30:0], acc_lo_q[31]};
					acc_lo_q <= {acc_lo_q[30:0], 1'b0};
				end
			end else begin
				acc_hi_q <= msum[32:1];
				acc_lo_q <= {msum[0], acc_lo_q[31:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= 32'd0;
			lo_q <= 32'd0;
		end else if (cmd.md_finish) begin
			if (div_q) begin
				lo_q <= neg_lo_q ? (32'd0 - acc_lo_q) : acc_lo_q;
				hi_q <= neg_hi_q ? (32'd0 - acc_hi_q) : acc_hi_q;
			end else begin
				lo_q <= neg_lo_q ? prod_neg[31:0] : acc_lo_q;
				hi_q <= neg_lo_q ? prod_neg[63:32] : acc_hi_q;
			end
		end else if (cmd.accept && op == OP_SPECIAL && fn == FN_MTHI) begin
			hi_q <= src_a;
		end else if (cmd.accept && op == OP_SPECIAL && fn == FN_MTLO) begin
			lo_q <= src_a;
		end
	end

endmodule
`default_nettype wire

// ----- src/miex_ctrl.sv -----
// Controller: request handshake, output valid and mul-div step sequencing.
`default_nettype none
module miex_ctrl import miex_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);

	ctl_state_t state_q, state_nx;
	logic [4:0] cnt_q;
	logic       out_valid_q;

	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (cmd.accept && status.md_req) state_nx = ST_RUN;
			ST_RUN:  if (cnt_q == 5'(MD_STEPS - 1)) state_nx = ST_FIX;
			ST_FIX:  state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE) || (out_valid_q && out_stall);
		cmd.accept    = in_valid && !in_stall;
		cmd.md_step   = (state_q == ST_RUN);
		cmd.md_finish = (state_q == ST_FIX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= (state_q == ST_RUN) ? cnt_q + 5'd1 : 5'd0;
			if (cmd.accept) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- src/mips_integer_execute_unit.sv -----
// Top level: MIPS I integer execute unit.
//
//  channel | handshake            | payload
//  input   | in_valid / in_stall   | instr_word, instr_addr, src_a, src_b
//  output  | out_valid / out_stall | dest_*, redirect*, mem_*, fault
//
// One request per cycle, if no result is stalled, for ALU, branch, jump,
// load/store and HI/LO moves; the result is registered and shows in the
// cycle after acceptance. mult/multu/div/divu occupy the shared mul-div unit
// (acceptance, 32 one-bit steps, sign fix); in_stall high in steps and fix.
// Reset clears HI, LO, output valid and the controller.
// A stalled result holds; a new request is taken in the cycle it leaves.
`default_nettype none
module mips_integer_execute_unit import miex_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instr_word,
	input  wire logic [31:0] instr_addr,
	input  wire logic [31:0] src_a,
	input  wire logic [31:0] src_b,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             dest_write,
	output logic             redirect,
	output logic [31:0]      redirect_target,
	output logic [3:0]       mem_kind,
	output logic [31:0]      mem_addr,
	output logic [31:0]      mem_store_data,
	output logic [2:0]       fault
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	miex_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	miex_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.instr_word(instr_word), .instr_addr(instr_addr), .src_a(src_a), .src_b(src_b),
		.dest_index(dest_index), .dest_value(dest_value), .dest_write(dest_write),
		.redirect(redirect), .redirect_target(redirect_target), .mem_kind(mem_kind),
		.mem_addr(mem_addr), .mem_store_data(mem_store_data), .fault(fault)
	);

	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid) else $error("accepted request gave no result");
	a_no_r0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dest_write |-> dest_index != 5'd0) else $error("write to r0");
	a_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !redirect |-> redirect_target == 32'd0) else $error("stray target");
	a_flt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault != FLT_NONE |-> !dest_write) else $error("write with fault");

endmodule
`default_nettype wire

// ----- tb/mips_integer_execute_unit_checker.sv -----
// Checker: watches both channels, predicts each execute result and compares it.
`timescale 1ns / 100ps
`default_nettype none
module mips_integer_execute_unit_checker import miex_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] instr_word,
	input  wire logic [31:0] instr_addr,
	input  wire logic [31:0] src_a,
	input  wire logic [31:0] src_b,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [4:0]  dest_index,
	input  wire logic [31:0] dest_value,
	input  wire logic        dest_write,
	input  wire logic        redirect,
	input  wire logic [31:0] redirect_target,
	input  wire logic [3:0]  mem_kind,
	input  wire logic [31:0] mem_addr,
	input  wire logic [31:0] mem_store_data,
	input  wire logic [2:0]  fault,
	output int               fail_count,
	output int               pending,
	output int               req_count,
	output int               rsp_count
);

	typedef struct packed {
		logic [4:0]  di;
		logic [31:0] dv;
		logic        dw;
		logic        rd;
		logic [31:0] tgt;
		mem_kind_t   mk;
		logic [31:0] ma;
		logic [31:0] msd;
		fault_t      flt;
	} exec_result_t;

	exec_result_t result_q[$];
	logic [31:0] hi_reg, lo_reg;

	function automatic logic slt_s(logic [31:0] x, logic [31:0] y);
		return $signed(x) < $signed(y);
	endfunction

	task automatic execute(input logic [31:0] iw, pc, a, b, output exec_result_t e);
		logic [5:0] op, fn;
		logic [4:0] rt, rd, sa;
		logic [31:0] imm, simm, btgt, ea, r, ma, mb, q, rm;
		logic [63:0] p;
		logic take;
		op = iw[31:26]; fn = iw[5:0]; rt = iw[20:16]; rd = iw[15:11]; sa = iw[10:6];
		imm = {16'h0, iw[15:0]};
		simm = {{16{iw[15]}}, iw[15:0]};
		btgt = pc + 32'd4 + (simm << 2);
		ea = a + simm;
		e = '0;
		e.mk = MK_NONE;
		e.flt = FLT_NONE;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL: begin e.di = rd; e.dv = b << sa; e.dw = 1; end
					FN_SRL: begin e.di = rd; e.dv = b >> sa; e.dw = 1; end
					FN_SRA: begin e.di = rd; e.dv = $signed(b) >>> sa; e.dw = 1; end
					FN_SLLV: begin e.di = rd; e.dv = b << a[4:0]; e.dw = 1; end
					FN_SRLV: begin e.di = rd; e.dv = b >> a[4:0]; e.dw = 1; end
					FN_SRAV: begin e.di = rd; e.dv = $signed(b) >>> a[4:0]; e.dw = 1; end
					FN_JR: begin e.rd = 1; e.tgt = a; end
					FN_JALR: begin e.rd = 1; e.tgt = a; e.di = rd; e.dv = pc + 8; e.dw = 1; end
					FN_SYSCALL: e.flt = FLT_SYS;
					FN_BREAK: e.flt = FLT_BRK;
					FN_MFHI: begin e.di = rd; e.dv = hi_reg; e.dw = 1; end
					FN_MTHI: hi_reg = a;
					FN_MFLO: begin e.di = rd; e.dv = lo_reg; e.dw = 1; end
					FN_MTLO: lo_reg = a;
					FN_MULT: begin
						p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
						lo_reg = p[31:0]; hi_reg = p[63:32];
					end
					FN_MULTU: begin
						p = {32'h0, a} * {32'h0, b};
						lo_reg = p[31:0]; hi_reg = p[63:32];
					end
					FN_DIV: begin
						if (b == 0) begin
							hi_reg = a; lo_reg = a[31] ? 32'd1 : 32'hFFFFFFFF;
						end else if (a == 32'h80000000 && b == 32'hFFFFFFFF) begin
							lo_reg = 32'h80000000; hi_reg = 0;
						end else begin
							ma = a[31] ? -a : a;
							mb = b[31] ? -b : b;
							q = ma / mb; rm = ma % mb;
							if (a[31] ^ b[31]) q = -q;
							if (a[31]) rm = -rm;
							lo_reg = q; hi_reg = rm;
						end
					end
					FN_DIVU: begin
						if (b == 0) begin
							lo_reg = 32'hFFFFFFFF; hi_reg = a;
						end else begin
							lo_reg = a / b; hi_reg = a % b;
						end
					end
					FN_ADD: begin
						r = a + b;
						if (~(a[31] ^ b[31]) & (a[31] ^ r[31])) e.flt = FLT_OVF;
						else begin e.di = rd; e.dv = r; e.dw = 1; end
					end
					FN_ADDU: begin e.di = rd; e.dv = a + b; e.dw = 1; end
					FN_SUB: begin
						r = a - b;
						if ((a[31] ^ b[31]) & (a[31] ^ r[31])) e.flt = FLT_OVF;
						else begin e.di = rd; e.dv = r; e.dw = 1; end
					end
					FN_SUBU: begin e.di = rd; e.dv = a - b; e.dw = 1; end
					FN_AND: begin e.di = rd; e.dv = a & b; e.dw = 1; end
					FN_OR: begin e.di = rd; e.dv = a | b; e.dw = 1; end
					FN_XOR: begin e.di = rd; e.dv = a ^ b; e.dw = 1; end
					FN_NOR: begin e.di = rd; e.dv = ~(a | b); e.dw = 1; end
					FN_SLT: begin e.di = rd; e.dv = {31'h0, slt_s(a, b)}; e.dw = 1; end
					FN_SLTU: begin e.di = rd; e.dv = {31'h0, a < b}; e.dw = 1; end
					FN_TEQ: if (a == b) e.flt = FLT_TRAP;
					FN_TNE: if (a != b) e.flt = FLT_TRAP;
					default: e.flt = FLT_RSVD;
				endcase
			end
			OP_REGIMM: begin
				if (rt == RI_BLTZ || rt == RI_BGEZ || rt == RI_BLTZAL || rt == RI_BGEZAL) begin
					take = rt[0] ? !a[31] : a[31];
					if (take) begin e.rd = 1; e.tgt = btgt; end
					if (rt[4]) begin e.di = LINK_REG; e.dv = pc + 8; e.dw = 1; end
				end else e.flt = FLT_RSVD;
			end
			OP_J, OP_JAL: begin
				e.rd = 1;
				e.tgt = ((pc + 32'd4) & 32'hF0000000) | {4'h0, iw[25:0], 2'b00};
				if (op == OP_JAL) begin e.di = LINK_REG; e.dv = pc + 8; e.dw = 1; end
			end
			OP_BEQ: if (a == b) begin e.rd = 1; e.tgt = btgt; end
			OP_BNE: if (a != b) begin e.rd = 1; e.tgt = btgt; end
			OP_BLEZ: if (!slt_s(0, a)) begin e.rd = 1; e.tgt = btgt; end
			OP_BGTZ: if (slt_s(0, a)) begin e.rd = 1; e.tgt = btgt; end
			OP_ADDI: begin
				r = a + simm;
				if (~(a[31] ^ simm[31]) & (a[31] ^ r[31])) e.flt = FLT_OVF;
				else begin e.di = rt; e.dv = r; e.dw = 1; end
			end
			OP_ADDIU: begin e.di = rt; e.dv = a + simm; e.dw = 1; end
			OP_SLTI: begin e.di = rt; e.dv = {31'h0, slt_s(a, simm)}; e.dw = 1; end
			OP_SLTIU: begin e.di = rt; e.dv = {31'h0, a < simm}; e.dw = 1; end
			OP_ANDI: begin e.di = rt; e.dv = a & imm; e.dw = 1; end
			OP_ORI: begin e.di = rt; e.dv = a | imm; e.dw = 1; end
			OP_XORI: begin e.di = rt; e.dv = a ^ imm; e.dw = 1; end
			OP_LUI: begin e.di = rt; e.dv = imm << 16; e.dw = 1; end
			OP_COP0, OP_CACHE: ;
			OP_LB: begin e.mk = MK_LB; e.ma = ea; e.di = rt; end
			OP_LBU: begin e.mk = MK_LBU; e.ma = ea; e.di = rt; end
			OP_LH, OP_LHU: begin
				e.ma = ea;
				if (ea[0]) e.flt = FLT_ADEL;
				else begin e.mk = (op == OP_LH) ? MK_LH : MK_LHU; e.di = rt; end
			end
			OP_LW: begin
				e.ma = ea;
				if (ea[1:0] != 0) e.flt = FLT_ADEL;
				else begin e.mk = MK_LW; e.di = rt; end
			end
			OP_LWL: begin e.mk = MK_LWL; e.ma = ea; e.di = rt; end
			OP_LWR: begin e.mk = MK_LWR; e.ma = ea; e.di = rt; end
			OP_SB: begin e.mk = MK_SB; e.ma = ea; e.msd = b; end
			OP_SH: begin e.mk = MK_SH; e.ma = ea; e.msd = b; end
			OP_SW: begin e.mk = MK_SW; e.ma = ea; e.msd = b; end
			OP_SWL: begin e.mk = MK_SWL; e.ma = ea; e.msd = b; end
			OP_SWR: begin e.mk = MK_SWR; e.ma = ea; e.msd = b; end
			default: e.flt = FLT_RSVD;
		endcase
		if (e.dw && e.di == 0) begin e.dw = 0; e.dv = 0; end
		if (!e.rd) e.tgt = 0;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		exec_result_t e, got;
		if (!arst_n) begin
			hi_reg = 0;
			lo_reg = 0;
			result_q.delete();
			fail_count <= 0;
			pending <= 0;
			req_count <= 0;
			rsp_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				execute(instr_word, instr_addr, src_a, src_b, e);
				result_q.push_back(e);
				req_count <= req_count + 1;
			end
			if (out_valid && !out_stall) begin
				got = '{dest_index, dest_value, dest_write, redirect, redirect_target,
					mem_kind_t'(mem_kind), mem_addr, mem_store_data, fault_t'(fault)};
				rsp_count <= rsp_count + 1;
				if (result_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					e = result_q.pop_front();
					if (got !== e) begin
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h", e, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= result_q.size();
		end
	end

endmodule
`default_nettype wire

// ----- tb/mips_integer_execute_unit_tb.sv -----
// Testbench top: drives execute requests under varied idling and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module mips_integer_execute_unit_tb;
	import miex_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [31:0] instr_word, instr_addr, src_a, src_b;
	logic [4:0] dest_index;
	logic [31:0] dest_value, redirect_target, mem_addr, mem_store_data;
	logic dest_write, redirect;
	logic [3:0] mem_kind;
	logic [2:0] fault;
	int fail_count, pending, req_count, rsp_count;
	int send_idle, recv_idle, idle_cycles;

	mips_integer_execute_unit uut (.*);
	mips_integer_execute_unit_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 0;
			idle_cycles <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return 32'h80000000;
			3: return 32'h7FFFFFFF;
			4: return $urandom_range(15) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_instr();
		logic [5:0] ops[30] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM,
			OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
			OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU,
			OP_LHU, OP_LWL, OP_LWR, OP_SB, OP_SH, OP_SW, OP_SWR};
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(19) == 0) return w;
		w[31:26] = ops[$urandom_range(29)];
		if (w[31:26] == OP_SPECIAL && $urandom_range(9) != 0) begin
			w[5:0] = 6'($urandom_range(FN_TNE));
			if ((w[5:0] == FN_MULT || w[5:0] == FN_DIV || w[5:0] == FN_MULTU ||
				w[5:0] == FN_DIVU) && $urandom_range(3) != 0) w[5:0] = FN_ADD;
		end
		if (w[31:26] == OP_REGIMM && $urandom_range(4) != 0)
			w[20:16] = {1'($urandom_range(1)), 3'b0, 1'($urandom)};
		if ($urandom_range(9) == 0) w[15:11] = 0;
		return w;
	endfunction

	task automatic send(input logic [31:0] iw, pc, a, b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		instr_word <= iw; instr_addr <= pc; src_a <= a; src_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || out_valid) @(posedge clk);
	endtask

	initial begin
		logic [31:0] a;
		in_valid = 0; instr_word = 0; instr_addr = 0; src_a = 0; src_b = 0;
		send_idle = 0; recv_idle = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send({OP_SPECIAL, 20'h00001, FN_MFHI}, 0, 0, 0);
		send({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD}, 0, 32'h7FFFFFFF, 1);
		send({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD}, 0, 32'h80000000, 32'h80000000);
		send({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_SUB}, 0, 32'h80000000, 1);
		send({OP_ADDI, 5'd1, 5'd2, 16'h0001}, 0, 32'h7FFFFFFF, 0);
		send({OP_LH, 5'd1, 5'd2, 16'h0001}, 0, 0, 0);
		send({OP_LW, 5'd1, 5'd2, 16'h0002}, 0, 0, 0);
		send({OP_LHU, 5'd1, 5'd2, 16'hFFFF}, 0, 0, 0);
		send({OP_SPECIAL, 5'd1, 5'd2, 10'd0, FN_DIV}, 0, 32'h80000000, 0);
		send({OP_SPECIAL, 15'h10, 5'd0, FN_MFLO}, 0, 0, 0);
		send({OP_SPECIAL, 5'd1, 5'd2, 10'd0, FN_DIV}, 0, 32'h80000000, 32'hFFFFFFFF);
		send({OP_SPECIAL, 15'h10, 5'd0, FN_MFHI}, 0, 0, 0);
		send({OP_SPECIAL, 5'd1, 5'd2, 10'd0, FN_DIVU}, 0, 5, 0);
		send({OP_SPECIAL, 15'h18, 5'd0, FN_MFLO}, 0, 0, 0);
		send({OP_SPECIAL, 5'd1, 5'd2, 10'd0, FN_MULT}, 0, 32'hFFFFFFFF, 32'h80000000);
		send({OP_SPECIAL, 15'h08, 5'd0, FN_MFHI}, 0, 0, 0);
		send({OP_SPECIAL, 5'd1, 5'd0, 5'd0, 5'd0, FN_ADDU}, 0, 1, 1);
		send({OP_REGIMM, 5'd1, RI_BLTZAL, 16'h8000}, 32'hFFFFFFFC, 0, 0);
		send({OP_JAL, 26'h3FFFFFF}, 32'hFFFFFFFC, 0, 0);
		send({OP_SPECIAL, 5'd1, 5'd1, 10'd0, FN_TEQ}, 0, 7, 7);
		send({OP_SPECIAL, 5'd1, 5'd1, 10'd0, FN_TNE}, 0, 7, 7);
		send({OP_COP0, 26'h1234567}, 0, 0, 0);
		send({OP_CACHE, 26'h1234567}, 0, 0, 0);
		send({6'h13, 26'h0}, 0, 0, 0);
		send({OP_SPECIAL, 20'h0, 6'h3F}, 0, 0, 0);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 49) : 0;
			recv_idle = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 49) : 0;
			for (int i = 0; i < 312; i++) begin
				a = pick_word();
				send(pick_instr(), $urandom, a, ($urandom_range(7) == 0) ? a : pick_word());
			end
			drain();
		end
		recv_idle = 0;
		repeat (40) @(posedge clk);
		$display("ran %0d requests and checked %0d results over four idling phases",
			req_count, rsp_count);
		if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
src/miex_pkg.sv
src/miex_dpath.sv
src/miex_ctrl.sv
src/mips_integer_execute_unit.sv
tb/mips_integer_execute_unit_checker.sv
tb/mips_integer_execute_unit_tb.sv
